// File: hw/rtl/swhs_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and reset values for the single-wire humidity sensor reader.
// No dependencies.
package swhs_pkg;

	localparam int DATA_BITS_DEF = 40;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;
	localparam int TICK_W     = 16;
	localparam int LIMIT_W    = 8;
	localparam int SINCE_W    = 22;
	localparam int BYTE_W     = 8;
	localparam int NUM_BYTES  = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_START_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESP_LIMIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_LOW      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_HIGH     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESH   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd6;

	localparam logic [TICK_W-1:0]  RST_START_LOW    = 16'd20000;
	localparam logic [LIMIT_W-1:0] RST_RELEASE_HIGH = 8'd40;
	localparam logic [LIMIT_W-1:0] RST_RESP_LIMIT   = 8'd80;
	localparam logic [LIMIT_W-1:0] RST_BIT_LOW      = 8'd50;
	localparam logic [LIMIT_W-1:0] RST_BIT_HIGH     = 8'd70;
	localparam logic [LIMIT_W-1:0] RST_ONE_THRESH   = 8'd28;
	localparam logic [SINCE_W-1:0] RST_MIN_INTERVAL = 22'd2000000;
	localparam logic [SINCE_W-1:0] SINCE_MAX        = '1;

	localparam logic ACT_TICK    = 1'b0;
	localparam logic ACT_REQUEST = 1'b1;

	localparam logic [1:0] LM_RELEASE = 2'd0;
	localparam logic [1:0] LM_LOW     = 2'd1;
	localparam logic [1:0] LM_HIGH    = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CHECKSUM = 2'd1;
	localparam logic [1:0] ST_TIMEOUT  = 2'd2;
	localparam logic [1:0] ST_NO_RESP  = 2'd3;

	typedef enum logic [6:0] {
		PH_IDLE       = 7'b0000001,
		PH_START_LOW  = 7'b0000010,
		PH_DRIVE_HIGH = 7'b0000100,
		PH_RESP_LOW   = 7'b0001000,
		PH_RESP_HIGH  = 7'b0010000,
		PH_BIT_LOW    = 7'b0100000,
		PH_BIT_HIGH   = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [TICK_W-1:0]  start_low_ticks;
		logic [LIMIT_W-1:0] release_high_ticks;
		logic [LIMIT_W-1:0] response_limit;
		logic [LIMIT_W-1:0] bit_low_limit;
		logic [LIMIT_W-1:0] bit_high_limit;
		logic [LIMIT_W-1:0] one_threshold;
		logic [SINCE_W-1:0] min_interval;
	} cfg_t;

	typedef struct packed {
		logic [1:0]                           line_mode;
		logic                                 busy;
		logic                                 done;
		logic [1:0]                           status;
		logic [NUM_BYTES-1:0][BYTE_W-1:0]     data;
	} res_t;

endpackage

// File: hw/rtl/swhs_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file: timing limits and read interval.
// Depends on swhs_pkg.
module swhs_cfg_regs import swhs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks    <= RST_START_LOW;
			cfg_q.release_high_ticks <= RST_RELEASE_HIGH;
			cfg_q.response_limit     <= RST_RESP_LIMIT;
			cfg_q.bit_low_limit      <= RST_BIT_LOW;
			cfg_q.bit_high_limit     <= RST_BIT_HIGH;
			cfg_q.one_threshold      <= RST_ONE_THRESH;
			cfg_q.min_interval       <= RST_MIN_INTERVAL;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_START_LOW:    cfg_q.start_low_ticks    <= wr_data[TICK_W-1:0];
				CFG_RELEASE_HIGH: cfg_q.release_high_ticks <= wr_data[LIMIT_W-1:0];
				CFG_RESP_LIMIT:   cfg_q.response_limit     <= wr_data[LIMIT_W-1:0];
				CFG_BIT_LOW:      cfg_q.bit_low_limit      <= wr_data[LIMIT_W-1:0];
				CFG_BIT_HIGH:     cfg_q.bit_high_limit     <= wr_data[LIMIT_W-1:0];
				CFG_ONE_THRESH:   cfg_q.one_threshold      <= wr_data[LIMIT_W-1:0];
				CFG_MIN_INTERVAL: cfg_q.min_interval       <= wr_data[SINCE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/swhs_fsm.sv
`timescale 1ns / 1ps
// Transaction sequencer: phase, tick counter, bit shifter, interval counter
// and checksum; one item per step. Depends on swhs_pkg.
module swhs_fsm import swhs_pkg::*; #(
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic step,
	input  logic action,
	input  logic line_level,
	output res_t res
);

	localparam int BIT_W = $clog2(DATA_BITS + 1);

	phase_t                 phase_q, phase_n;
	logic [TICK_W-1:0]      ticks_q, ticks_n, ticks_inc;
	logic [BIT_W-1:0]       bit_q, bit_n, bit_inc;
	logic [DATA_BITS-1:0]   rx_q, rx_n, rx_shift;
	logic [SINCE_W-1:0]     since_q, since_n;
	logic                   done, data_ok;
	logic [1:0]             status;
	logic                   wait_level;
	logic [LIMIT_W-1:0]     wait_limit;
	logic [BYTE_W+1:0]      sum;

	assign ticks_inc = ticks_q + TICK_W'(1);
	assign bit_inc   = bit_q + BIT_W'(1);
	assign rx_shift  = {rx_q[DATA_BITS-2:0],
		(ticks_q > {{(TICK_W-LIMIT_W){1'b0}}, cfg.one_threshold})};
	assign sum = (BYTE_W+2)'(rx_shift[DATA_BITS-1 -: BYTE_W])
		+ (BYTE_W+2)'(rx_shift[DATA_BITS-1-BYTE_W -: BYTE_W])
		+ (BYTE_W+2)'(rx_shift[DATA_BITS-1-2*BYTE_W -: BYTE_W])
		+ (BYTE_W+2)'(rx_shift[DATA_BITS-1-3*BYTE_W -: BYTE_W]);

	always_comb begin
		wait_level = 1'b0;
		wait_limit = cfg.response_limit;
		unique case (phase_q) inside
			PH_RESP_HIGH: begin
				wait_level = 1'b1;
			end
			PH_BIT_LOW: begin
				wait_limit = cfg.bit_low_limit;
			end
			PH_BIT_HIGH: begin
				wait_level = 1'b1;
				wait_limit = cfg.bit_high_limit;
			end
			default: ;
		endcase
	end

	always_comb begin
		phase_n = phase_q;
		ticks_n = ticks_q;
		bit_n   = bit_q;
		rx_n    = rx_q;
		since_n = since_q;
		done    = 1'b0;
		status  = ST_OK;
		data_ok = 1'b0;
		if (action == ACT_REQUEST) begin
			if (phase_q != PH_IDLE) begin
				phase_n = phase_q;
			end else if (since_q < cfg.min_interval) begin
				done   = 1'b1;
				status = ST_TIMEOUT;
			end else begin
				since_n = '0;
				phase_n = PH_START_LOW;
				ticks_n = '0;
				bit_n   = '0;
				rx_n    = '0;
			end
		end else begin
			if (since_q != SINCE_MAX)
				since_n = since_q + SINCE_W'(1);
			unique case (phase_q) inside
				PH_START_LOW: begin
					ticks_n = ticks_inc;
					if (ticks_inc >= cfg.start_low_ticks) begin
						phase_n = PH_DRIVE_HIGH;
						ticks_n = '0;
					end
				end
				PH_DRIVE_HIGH: begin
					ticks_n = ticks_inc;
					if (ticks_inc >= {{(TICK_W-LIMIT_W){1'b0}}, cfg.release_high_ticks}) begin
						phase_n = PH_RESP_LOW;
						ticks_n = '0;
					end
				end
				PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
					if (line_level == wait_level) begin
						if (ticks_q > {{(TICK_W-LIMIT_W){1'b0}}, wait_limit}) begin
							phase_n = PH_IDLE;
							ticks_n = '0;
							done    = 1'b1;
							status  = (phase_q == PH_RESP_LOW || phase_q == PH_RESP_HIGH)
								? ST_NO_RESP : ST_TIMEOUT;
						end else begin
							ticks_n = ticks_inc;
						end
					end else begin
						ticks_n = TICK_W'(1);
						if (phase_q == PH_BIT_HIGH) begin
							rx_n  = rx_shift;
							bit_n = bit_inc;
							if (bit_inc >= BIT_W'(DATA_BITS)) begin
								phase_n = PH_IDLE;
								ticks_n = '0;
								done    = 1'b1;
								if (sum[BYTE_W-1:0] == rx_shift[BYTE_W-1:0]) begin
									status  = ST_OK;
									data_ok = 1'b1;
								end else begin
									status = ST_CHECKSUM;
								end
							end else begin
								phase_n = PH_BIT_LOW;
							end
						end else if (phase_q == PH_RESP_HIGH) begin
							phase_n = PH_BIT_LOW;
						end else if (phase_q == PH_RESP_LOW) begin
							phase_n = PH_RESP_HIGH;
						end else begin
							phase_n = PH_BIT_HIGH;
						end
					end
				end
				default: begin
					phase_n = PH_IDLE;
					ticks_n = '0;
				end
			endcase
		end
	end

	always_comb begin
		res.line_mode = (phase_n == PH_START_LOW) ? LM_LOW
			: (phase_n == PH_DRIVE_HIGH) ? LM_HIGH : LM_RELEASE;
		res.busy   = (phase_n != PH_IDLE);
		res.done   = done;
		res.status = status;
		for (int j = 0; j < NUM_BYTES; j++)
			res.data[NUM_BYTES-1-j] = data_ok
				? rx_n[DATA_BITS-1-BYTE_W*j -: BYTE_W] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ticks_q <= '0;
			bit_q   <= '0;
			rx_q    <= '0;
			since_q <= SINCE_MAX;
		end else if (step) begin
			phase_q <= phase_n;
			ticks_q <= ticks_n;
			bit_q   <= bit_n;
			rx_q    <= rx_n;
			since_q <= since_n;
		end
	end

endmodule

// File: hw/rtl/swhs_out_queue.sv
`timescale 1ns / 1ps
// Two-entry result queue: output register plus skid slot.
// Depends on swhs_pkg.
module swhs_out_queue import swhs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic space,
	input  logic out_stall,
	output logic out_valid,
	output res_t out_data
);

	logic [1:0] cnt_q;
	res_t       head_q, skid_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign space     = (cnt_q != 2'd2) || !out_stall;
	assign out_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && cnt_q == 2'd1)
				head_q <= push_data;
			else
				head_q <= skid_q;
			if (push && cnt_q == 2'd2)
				skid_q <= push_data;
		end else if (push) begin
			if (cnt_q == 2'd0)
				head_q <= push_data;
			else
				skid_q <= push_data;
		end
	end

endmodule

// File: hw/rtl/single_wire_humidity_sensor_reader_core.sv
`timescale 1ns / 1ps
// Top level of the single-wire humidity sensor reader.
// Depends on swhs_pkg, swhs_cfg_regs, swhs_fsm, swhs_out_queue.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | action, line_level
//  out      | out_valid / out_stall| line_mode, busy_res, done_res, status, 4 bytes
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One beat per clock unless the result queue is full and out_stall holds it; a result
// passes through the input register, then the sequencer into the result queue, and is
// offered from the head of that queue.
// The sequencer state is one-hot; all counters advance only on processed beats.
// Reset clears control state and loads register defaults; no clearing pass.
// A two-entry result queue lets input beats continue while one result waits.
module single_wire_humidity_sensor_reader_core import swhs_pkg::*; #(
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  action,
	input  logic                  line_level,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            line_mode,
	output logic                  busy_res,
	output logic                  done_res,
	output logic [1:0]            status,
	output logic [BYTE_W-1:0]     humidity_whole,
	output logic [BYTE_W-1:0]     humidity_tenths,
	output logic [BYTE_W-1:0]     temperature_whole,
	output logic [BYTE_W-1:0]     temperature_tenths,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	res_t res, out_res;
	logic valid_s1, action_s1, line_s1;
	logic space, proc;

	assign cfg_ready = 1'b1;
	assign proc      = valid_s1 && space;
	assign in_stall  = valid_s1 && !space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			line_s1   <= line_level;
		end
	end

	swhs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	swhs_fsm #(
		.DATA_BITS (DATA_BITS)
	) u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step       (proc),
		.action     (action_s1),
		.line_level (line_s1),
		.res        (res)
	);

	swhs_out_queue u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (proc),
		.push_data (res),
		.space     (space),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_res)
	);

	assign line_mode          = out_res.line_mode;
	assign busy_res           = out_res.busy;
	assign done_res           = out_res.done;
	assign status             = out_res.status;
	assign humidity_whole     = out_res.data[3];
	assign humidity_tenths    = out_res.data[2];
	assign temperature_whole  = out_res.data[1];
	assign temperature_tenths = out_res.data[0];

endmodule
